// ===== src/ntc_avg_pkg.sv =====
// Package for the NTC thermistor averager: constants, log table and shared types.
// No dependencies.
`default_nettype none
package ntc_avg_pkg;
   localparam logic [22:0] VDIV_K       = 23'd4914000;
   // Rounded-up 2^28 * 6553600 / 29815; the beta offset is (beta * BETA_RECIP) >> 28.
   localparam logic [35:0] BETA_RECIP   =
      36'((64'd6553600 * 64'd268435456 + 64'd29814) / 64'd29815);
   localparam int          LN2_Q16      = 45426;
   localparam int          KELVIN_Q16   = 17901158;
   localparam int          TEMP_MAX_Q16 = 16777216;
   localparam int          T19_Q16      = 19 * 65536;
   localparam int          T23_Q16      = 23 * 65536;
   localparam int          T60_Q16      = 60 * 65536;
   localparam int          CORR_LO      = 85197;
   localparam int          CORR_MID     = 104858;
   localparam int          CORR_HI      = 117965;
   localparam int          DIV_W        = 64;

   typedef struct packed {
      logic start;
      logic numer_neg;
      logic denom_neg;
   } div_ctrl_type;

   function automatic logic [15:0] ln_tab(input logic [4:0] i);
      case (i)
         5'd0: ln_tab = 16'd0;      5'd1: ln_tab = 16'd3973;
         5'd2: ln_tab = 16'd7719;   5'd3: ln_tab = 16'd11262;
         5'd4: ln_tab = 16'd14624;  5'd5: ln_tab = 16'd17822;
         5'd6: ln_tab = 16'd20870;  5'd7: ln_tab = 16'd23783;
         5'd8: ln_tab = 16'd26573;  5'd9: ln_tab = 16'd29248;
         5'd10: ln_tab = 16'd31818; 5'd11: ln_tab = 16'd34292;
         5'd12: ln_tab = 16'd36675; 5'd13: ln_tab = 16'd38975;
         5'd14: ln_tab = 16'd41197; 5'd15: ln_tab = 16'd43345;
         5'd16: ln_tab = 16'd45426;
         default: ln_tab = 16'd0;
      endcase
   endfunction
endpackage
`default_nettype wire

// ===== src/ntc_thermistor_temperature_average.sv =====
// Top level of the NTC thermistor averager: sequencer, log, accumulate, batch result.
// Depends on ntc_avg_pkg and ntc_avg_div.
//
//  channel | dir | fields
//  req     | in  | tdata[11:0] adc_raw
//  rsp     | out | tdata[7:0] temp_half_deg, tuser[0] reading_valid
//  csr     | in  | index 0 vref_mv, index 1 beta_value
//
// A sample is accepted, its resistance ratio is divided out on the shared radix-4
// divider, the log is taken, Kelvin is divided out on the same divider and the result
// is accumulated. The last sample of a batch then goes on to the reciprocal-multiply
// average and the correction. Reset is synchronous and clears the batch state. The
// result sits in an output register; req_tready stays low until it is taken.
`default_nettype none
module ntc_thermistor_temperature_average
   import ntc_avg_pkg::*;
#(
   parameter int SAMPLES = 10
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] adc_raw
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] temp_half_deg
   output logic             rsp_tuser,   // [0] reading_valid
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_wdata
);
   localparam logic [3:0] S_IDLE = 4'd0, S_XW = 4'd1, S_LN = 4'd2,
                          S_KS = 4'd4, S_KW = 4'd5, S_ACC = 4'd6, S_AW = 4'd7,
                          S_FIN = 4'd8, S_OUT = 4'd9, S_XS = 4'd10;
   localparam logic [3:0] BATCH = 4'(SAMPLES);
   localparam logic [35:0] AVG_RECIP =
      36'(((64'd1 << 35) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

   logic [3:0]  st_ff, st_in, cnt_ff, cnt_in;
   logic [10:0] vref_ff;
   logic [12:0] beta_ff;
   logic [11:0] raw_ff, raw_in;
   logic signed [31:0] sum_ff, sum_in;
   logic        pois_ff, pois_in, ovld_ff, ovld_in;
   logic [7:0]  odat_ff, odat_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [20:0] b_ff, b_in;
   logic [48:0] bprod;
   logic [67:0] avg_prod;
   logic [31:0] avg_q;
   div_ctrl_type dctl;
   logic [DIV_W-1:0] dnum, dden;
   logic        ddone;
   logic signed [DIV_W:0] dq;
   logic [5:0]  p;
   logic [15:0] m, t0, t1;
   logic [3:0]  li;
   logic [11:0] lr;
   logic signed [31:0] lnv;
   logic signed [63:0] c, t2, avg, corr, n;
   logic [63:0] xu;

   ntc_avg_div u_div (.clock(clock), .reset(reset), .ctrl(dctl), .numer_mag(dnum),
      .denom_mag(dden), .done(ddone), .quot(dq));

   always_comb begin
      bprod = 49'(beta_ff) * 49'(BETA_RECIP);
      b_in = bprod[48:28];
      avg_prod = 68'(acc_ff[31:0]) * 68'(AVG_RECIP);
      avg_q = avg_prod[66:35];
   end

   always_comb begin
      xu = acc_ff[63:0];
      p = '0;
      for (int k = 0; k < 64; k++) if (xu[k]) p = 6'(k);
      m = (p >= 6'd16) ? 16'(xu >> (p - 6'd16)) : 16'(xu << (6'd16 - p));
      li = m[15:12];
      lr = m[11:0];
      t0 = ln_tab({1'b0, li});
      t1 = ln_tab({1'b0, li} + 5'd1);
      lnv = 32'(($signed({26'd0, p}) - 32'sd16) * LN2_Q16)
          + $signed({16'd0, t0}) + 32'(($signed({16'd0, 16'(t1 - t0)}) * lr) >>> 12);
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; raw_in = raw_ff; sum_in = sum_ff;
      pois_in = pois_ff; ovld_in = ovld_ff; odat_in = odat_ff; acc_in = acc_ff;
      dctl = '0; dnum = '0; dden = '0;
      c = '0; t2 = '0; avg = '0; corr = '0; n = '0;
      case (st_ff)
         S_IDLE: if (req_tvalid) begin
            raw_in = req_tdata[11:0];
            st_in = S_XS;
         end
         S_XS: begin
            if (vref_ff == '0 || raw_ff == '0) begin
               pois_in = 1'b1;
               st_in = S_ACC;
            end else begin
               dctl.start = 1'b1;
               dnum = {25'd0, VDIV_K, 16'd0};
               dden = {41'd0, 23'(vref_ff * raw_ff)};
               st_in = S_XW;
            end
         end
         S_XW: if (ddone) begin
            acc_in = 64'(dq) - 64'sd65536;
            if (64'(dq) <= 64'sd65536) begin
               pois_in = 1'b1;
               st_in = S_ACC;
            end else begin
               st_in = S_LN;
            end
         end
         S_LN: begin
            acc_in = 64'(lnv) + 64'($signed({1'b0, b_ff}));
            st_in = S_KS;
         end
         S_KS: begin
            if (acc_ff == '0) begin
               pois_in = 1'b1;
               st_in = S_ACC;
            end else begin
               dctl.start = 1'b1;
               dctl.denom_neg = acc_ff[63];
               dnum = {19'd0, beta_ff, 32'd0};
               dden = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
               st_in = S_KW;
            end
         end
         S_KW: if (ddone) begin
            c = 64'(dq) - 64'(KELVIN_Q16);
            if (c < -64'(TEMP_MAX_Q16) || c >= 64'(TEMP_MAX_Q16)) pois_in = 1'b1;
            else sum_in = 32'(sum_ff + c);
            st_in = S_ACC;
         end
         S_ACC: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_in < BATCH) begin
               st_in = S_IDLE;
            end else begin
               acc_in = sum_ff[31] ? -64'(sum_ff) : 64'(sum_ff);
               st_in = S_AW;
            end
         end
         S_AW: begin
            acc_in = sum_ff[31] ? -64'({32'd0, avg_q}) : 64'({32'd0, avg_q});
            st_in = S_FIN;
         end
         S_FIN: begin
            avg = acc_ff;
            ovld_in = !pois_ff && avg > 0 && avg <= 64'(T60_Q16);
            corr = (avg < 64'(T19_Q16)) ? 64'(CORR_LO) :
                   (avg < 64'(T23_Q16)) ? 64'(CORR_MID) : 64'(CORR_HI);
            t2 = 2 * (avg - corr);
            n = (t2 >= 0) ? ((t2 + 32768) >>> 16) : -((-t2 + 32768) >>> 16);
            odat_in = ovld_in ? n[7:0] : 8'd0;
            cnt_in = '0; sum_in = '0; pois_in = 1'b0;
            st_in = S_OUT;
         end
         S_OUT: if (rsp_tready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; sum_ff <= '0; pois_ff <= 1'b0;
         vref_ff <= 11'd1100; beta_ff <= 13'd3950;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; sum_ff <= sum_in; pois_ff <= pois_in;
         if (csr_we && csr_index == 1'b0) vref_ff <= csr_wdata[10:0];
         if (csr_we && csr_index == 1'b1) beta_ff <= csr_wdata;
      end
      raw_ff <= raw_in; acc_ff <= acc_in; ovld_ff <= ovld_in; odat_ff <= odat_in;
      b_ff <= b_in;
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tdata  = odat_ff;
   assign rsp_tuser  = ovld_ff;

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= BATCH || BATCH == 4'd0)
      else $error("sample count past batch");
   a_excl: assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid))
      else $error("ready while result pending");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0) else $error("invalid result not zero");
`endif
endmodule
`default_nettype wire

// ===== src/ntc_avg_div.sv =====
// Radix-4 shared signed divider, truncating toward zero, magnitudes up to 64 bits.
// Depends on ntc_avg_pkg.
`default_nettype none
module ntc_avg_div
   import ntc_avg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire div_ctrl_type        ctrl,
   input  wire logic [DIV_W-1:0]    numer_mag,
   input  wire logic [DIV_W-1:0]    denom_mag,
   output logic                     done,
   output logic signed [DIV_W:0]    quot
);
   logic [DIV_W-1:0] rem_ff, rem_in, num_ff, num_in, den_ff, den_in, q_ff, q_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [DIV_W:0]   r1, r2;
   logic [DIV_W-1:0] ra;
   logic             b1, b2;

   always_comb begin
      rem_in = rem_ff; num_in = num_ff; den_in = den_ff; q_in = q_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      r1 = {rem_ff, num_ff[DIV_W-1]};
      b1 = r1 >= {1'b0, den_ff};
      ra = b1 ? DIV_W'(r1 - {1'b0, den_ff}) : r1[DIV_W-1:0];
      r2 = {ra, num_ff[DIV_W-2]};
      b2 = r2 >= {1'b0, den_ff};
      if (ctrl.start) begin
         rem_in = '0; num_in = numer_mag; den_in = denom_mag; q_in = '0;
         cnt_in = '0; busy_in = 1'b1; neg_in = ctrl.numer_neg ^ ctrl.denom_neg;
      end else if (busy_ff) begin
         rem_in = b2 ? DIV_W'(r2 - {1'b0, den_ff}) : r2[DIV_W-1:0];
         num_in = {num_ff[DIV_W-3:0], 2'b00};
         q_in   = {q_ff[DIV_W-3:0], b1, b2};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; num_ff <= num_in; den_ff <= den_in; q_ff <= q_in; neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
endmodule
`default_nettype wire
